// ===== design/foc_pkg.sv =====
// ----------------------------------------------------------------------------
// foc_pkg
// Shared constants, types, the sine table and saturation helpers of the
// dq current loop.
// ----------------------------------------------------------------------------
package foc_pkg;

	localparam int SINE_TABLE_ENTRIES = 1024;
	localparam int SINE_IDX_W = $clog2(SINE_TABLE_ENTRIES);

	localparam logic [63:0] QA = 64'd1686629713;
	localparam logic [63:0] QB = 64'd688904866;
	localparam logic [63:0] QC = 64'd76016977;
	localparam logic [30:0] TWO_THIRDS_Q31 = 31'd1431655751;
	localparam logic [31:0] INV_SQRT3_Q32 = 32'd2479700525;
	localparam logic [31:0] THIRD_TURN = 32'h5555_5555;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [31:0] MAG_FLOOR = 32'd66;
	localparam logic [31:0] SAMPLE_PERIOD_RST = 32'd268435;
	localparam int CFG_IDX_W = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP_D = 4'd0,
		REG_KI_D = 4'd1,
		REG_KP_Q = 4'd2,
		REG_KI_Q = 4'd3,
		REG_SAMPLE_PERIOD = 4'd4,
		REG_INDUCTANCE_D = 4'd5,
		REG_INDUCTANCE_Q = 4'd6,
		REG_FLUX_LINKAGE = 4'd7
	} cfg_reg_t;

	typedef enum logic [5:0] {
		S_IDLE, S_LUT, S_SMUL, S_SCUR, S_SACC,
		S_PRKD, S_PRKQ, S_PRKE,
		S_PI0, S_PI1, S_PI2, S_PI3, S_PI4, S_PI5,
		S_FF0, S_FF1, S_FF2, S_FF3, S_FF4, S_FF5,
		S_SQ0, S_SQ1, S_SQ2, S_VMAX, S_SQW,
		S_LIM0, S_LIM1, S_LIM2, S_DONE
	} state_t;

	typedef logic signed [16:0] sine_tab_t [SINE_TABLE_ENTRIES];

	function automatic logic signed [16:0] poly_sine(input logic [31:0] ph);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] u;
		logic [63:0] y;
		logic [63:0] r;
		x = {34'd0, ph[29:0]};
		if (ph[30]) begin
			x = 64'h4000_0000 - x;
		end
		x2 = (x * x) >> 30;
		t = QB - ((x2 * QC) >> 30);
		u = QA - ((x2 * t) >> 30);
		y = (x * u) >> 30;
		r = (y + 64'h4000) >> 15;
		if (r > 64'd32768) begin
			r = 64'd32768;
		end
		return ph[31] ? -$signed(17'(r)) : $signed(17'(r));
	endfunction

	function automatic sine_tab_t build_sine_tab();
		sine_tab_t tab;
		for (int k = 0; k < SINE_TABLE_ENTRIES; k++) begin
			tab[k] = poly_sine(32'((64'(k) << 32) / SINE_TABLE_ENTRIES));
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

	function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
		if (v > 72'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end else if (v < -72'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [71:0] v);
		if (v > 72'sd32767) begin
			return 16'sh7FFF;
		end else if (v < -72'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	function automatic logic signed [71:0] rnd32(input logic signed [71:0] v);
		return (v + 72'sh8000_0000) >>> 32;
	endfunction

endpackage

// ===== design/foc_ifs.sv =====
// ----------------------------------------------------------------------------
// foc interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface foc_sample_if;
	logic valid;
	logic ready;
	logic signed [15:0] phase_current_a;
	logic signed [15:0] phase_current_b;
	logic signed [15:0] phase_current_c;
	logic [15:0] rotor_angle;
	logic signed [15:0] current_ref_d;
	logic signed [15:0] current_ref_q;
	logic signed [15:0] electrical_speed;
	logic [15:0] bus_voltage;
	modport source (output valid, phase_current_a, phase_current_b, phase_current_c,
		rotor_angle, current_ref_d, current_ref_q, electrical_speed, bus_voltage,
		input ready);
	modport sink (input valid, phase_current_a, phase_current_b, phase_current_c,
		rotor_angle, current_ref_d, current_ref_q, electrical_speed, bus_voltage,
		output ready);
endinterface

interface foc_result_if;
	logic valid;
	logic ready;
	logic signed [15:0] voltage_ref_d;
	logic signed [15:0] voltage_ref_q;
	logic signed [15:0] measured_d;
	logic signed [15:0] measured_q;
	logic limited;
	modport source (output valid, voltage_ref_d, voltage_ref_q, measured_d, measured_q,
		limited, input ready);
	modport sink (input valid, voltage_ref_d, voltage_ref_q, measured_d, measured_q,
		limited, output ready);
endinterface

interface foc_cfg_if;
	logic valid;
	logic ready;
	logic [3:0] index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/foc_mul.sv =====
// ----------------------------------------------------------------------------
// foc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module foc_mul (
	input logic clk,
	input logic signed [35:0] a,
	input logic signed [35:0] b,
	output logic signed [71:0] prod
);
	always_ff @(posedge clk) begin
		prod <= a * b;
	end
endmodule

// ===== design/foc_sqrt.sv =====
// ----------------------------------------------------------------------------
// foc_sqrt
// Iterative floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module foc_sqrt
	import foc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [63:0] radicand,
	output logic done,
	output logic [31:0] root
);
	logic run_q;
	logic done_q;
	logic [63:0] v_q;
	logic [63:0] r_q;
	logic [63:0] bit_q;
	logic [63:0] trial;

	assign trial = r_q + bit_q;
	assign done = done_q;
	assign root = r_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && bit_q[0];
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && bit_q[0]) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= radicand;
			r_q <= '0;
			bit_q <= 64'd1 << 62;
		end else if (run_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
endmodule

// ===== design/foc_div.sv =====
// ----------------------------------------------------------------------------
// foc_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module foc_div
	import foc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [63:0] dividend,
	input logic [31:0] divisor,
	output logic done,
	output logic [63:0] quotient
);
	logic run_q;
	logic done_q;
	logic [5:0] cnt_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [63:0] quo_q;
	logic [32:0] shifted;
	logic take;

	assign shifted = {rem_q, quo_q[63]};
	assign take = shifted >= {1'b0, dvs_q};
	assign done = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= run_q && (cnt_q == 6'd0);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'd63;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= take ? 32'(shifted - {1'b0, dvs_q}) : shifted[31:0];
			quo_q <= {quo_q[62:0], take};
		end
	end
endmodule

// ===== design/foc_current_loop.sv =====
// The loop takes no new sample until the previous result is in the output register.
// Most of the time per sample goes to the 64-step divider, run once per axis, and the
// 32-step square root.
// A new sample is accepted while the previous result still waits in the output register.
// Reset sets control and configuration registers to their reset values, integrators and clamp excess to zero.
// ----------------------------------------------------------------------------
// foc_current_loop
// Park transform, two PI current regulators with anti-windup, speed
// feed-forward and voltage vector limiting around one shared multiplier.
// ----------------------------------------------------------------------------
module foc_current_loop
	import foc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	foc_sample_if.sink sample,
	foc_result_if.source result,
	foc_cfg_if.sink cfg
);
	state_t st_q, st_d;
	logic ax_q;
	logic [2:0] j_q;

	logic [31:0] kp_d_q, ki_d_q, kp_q_q, ki_q_q, sp_q, ld_q, lq_q, flux_q;
	logic signed [31:0] integ_q [2];
	logic signed [31:0] exc_q [2];

	logic signed [15:0] ia_q, ib_q, ic_q, refd_q, refq_q, spd_q;
	logic [15:0] ang_q, vdc_q;
	logic signed [16:0] t0_q, t1_q;
	logic [31:0] frac_q;
	logic signed [33:0] sd_q, sq_q;
	logic signed [15:0] id_q, iq_q;
	logic signed [16:0] err_q;
	logic signed [31:0] w_q, hi_q;
	logic [32:0] lor_q;
	logic signed [47:0] p_q [2];
	logic signed [39:0] ffd_q, ffq_q;
	logic signed [31:0] vu_q [2];
	logic signed [31:0] vl_q [2];
	logic [63:0] sum_q;
	logic [23:0] vmax_q;
	logic [31:0] mag_q;
	logic hit_q;

	logic res_valid_q;
	logic signed [15:0] res_vd_q, res_vq_q, res_md_q, res_mq_q;
	logic res_lim_q;

	logic signed [35:0] mul_a, mul_b;
	logic signed [71:0] prod;
	logic sq_start, sq_done;
	logic [31:0] sq_root;
	logic dv_start, dv_done;
	logic [63:0] dv_quo;

	logic [31:0] ph_c;
	logic [SINE_IDX_W-1:0] idx_c;
	logic signed [15:0] cur_c;
	logic signed [16:0] s_c;
	logic signed [71:0] rnd_c;
	logic signed [15:0] park_c;
	logic signed [16:0] err_c;
	logic signed [31:0] w_c, integ_c, vd_c, vq_c, vl_c, vsel_c;
	logic signed [71:0] inc_c;
	logic signed [47:0] pout_c;
	logic [31:0] av_c, kp_c, ki_c;
	logic signed [65:0] lim_c, v66_c;
	logic accept, out_free;

	foc_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));
	foc_sqrt u_sqrt (.clk(clk), .arst_n(arst_n), .start(sq_start),
		.radicand(sum_q + prod[63:0]), .done(sq_done), .root(sq_root));
	foc_div u_div (.clk(clk), .arst_n(arst_n), .start(dv_start),
		.dividend(prod[63:0]), .divisor(mag_q), .done(dv_done), .quotient(dv_quo));

	assign sample.ready = (st_q == S_IDLE);
	assign accept = sample.valid && sample.ready;
	assign cfg.ready = 1'b1;
	assign out_free = !res_valid_q || result.ready;
	assign result.valid = res_valid_q;
	assign result.voltage_ref_d = res_vd_q;
	assign result.voltage_ref_q = res_vq_q;
	assign result.measured_d = res_md_q;
	assign result.measured_q = res_mq_q;
	assign result.limited = res_lim_q;

	always_comb begin
		case (j_q)
			3'd0: ph_c = {ang_q, 16'h0};
			3'd1: ph_c = {ang_q, 16'h0} - THIRD_TURN;
			3'd2: ph_c = {ang_q, 16'h0} + THIRD_TURN;
			3'd3: ph_c = {ang_q, 16'h0} + QUARTER_TURN;
			3'd4: ph_c = {ang_q, 16'h0} - THIRD_TURN + QUARTER_TURN;
			default: ph_c = {ang_q, 16'h0} + THIRD_TURN + QUARTER_TURN;
		endcase
		case (j_q)
			3'd0, 3'd3: cur_c = ia_q;
			3'd1, 3'd4: cur_c = ib_q;
			default: cur_c = ic_q;
		endcase
		idx_c = ph_c[31 -: SINE_IDX_W];
		rnd_c = rnd32(prod);
		s_c = 17'(72'(t0_q) + rnd_c);
		park_c = sat16((prod + (72'sd1 <<< 45)) >>> 46);
		kp_c = ax_q ? kp_q_q : kp_d_q;
		ki_c = ax_q ? ki_q_q : ki_d_q;
		err_c = ax_q ? 17'(refq_q) - 17'(iq_q) : 17'(refd_q) - 17'(id_q);
		w_c = sat32((72'(err_c) <<< 8) + 72'(exc_q[ax_q]));
		inc_c = ((prod + $signed({39'd0, lor_q})) + 72'sh8000) >>> 16;
		integ_c = sat32(72'(integ_q[ax_q]) + inc_c);
		pout_c = 48'(((prod + 72'sd128) >>> 8) + 72'(integ_q[ax_q]));
		vd_c = sat32(72'(p_q[0]) - 72'(ffd_q));
		vq_c = sat32(72'(p_q[1]) + 72'(ffq_q) + rnd_c);
		vsel_c = vu_q[ax_q];
		av_c = 32'(vsel_c[31] ? -vsel_c : vsel_c);
		v66_c = 66'(vsel_c);
		lim_c = $signed({2'b00, dv_quo});
		if (v66_c > lim_c) begin
			vl_c = lim_c[31:0];
		end else if (v66_c < -lim_c) begin
			vl_c = 32'(-lim_c);
		end else begin
			vl_c = vsel_c;
		end
	end

	always_comb begin
		st_d = st_q;
		mul_a = '0;
		mul_b = '0;
		sq_start = 1'b0;
		dv_start = 1'b0;
		case (st_q)
			S_IDLE: begin
				if (accept) st_d = S_LUT;
			end
			S_LUT: st_d = S_SMUL;
			S_SMUL: begin
				mul_a = 36'(t1_q - t0_q);
				mul_b = $signed({4'd0, frac_q});
				st_d = S_SCUR;
			end
			S_SCUR: begin
				mul_a = 36'(s_c);
				mul_b = 36'(cur_c);
				st_d = S_SACC;
			end
			S_SACC: st_d = (j_q == 3'd5) ? S_PRKD : S_LUT;
			S_PRKD: begin
				mul_a = 36'(sd_q);
				mul_b = $signed({5'd0, TWO_THIRDS_Q31});
				st_d = S_PRKQ;
			end
			S_PRKQ: begin
				mul_a = 36'(sq_q);
				mul_b = $signed({5'd0, TWO_THIRDS_Q31});
				st_d = S_PRKE;
			end
			S_PRKE: st_d = S_PI0;
			S_PI0: st_d = S_PI1;
			S_PI1: begin
				mul_a = $signed({4'd0, ki_c});
				mul_b = 36'(w_q);
				st_d = S_PI2;
			end
			S_PI2: begin
				mul_a = $signed({4'd0, prod[31:0]});
				mul_b = $signed({4'd0, sp_q});
				st_d = S_PI3;
			end
			S_PI3: begin
				mul_a = 36'(hi_q);
				mul_b = $signed({4'd0, sp_q});
				st_d = S_PI4;
			end
			S_PI4: begin
				mul_a = $signed({4'd0, kp_c});
				mul_b = 36'(err_q);
				st_d = S_PI5;
			end
			S_PI5: st_d = ax_q ? S_FF0 : S_PI0;
			S_FF0: begin
				mul_a = 36'(iq_q);
				mul_b = 36'(spd_q);
				st_d = S_FF1;
			end
			S_FF1: begin
				mul_a = $signed({prod[31:0], 4'd0});
				mul_b = $signed({4'd0, lq_q});
				st_d = S_FF2;
			end
			S_FF2: begin
				mul_a = 36'(id_q);
				mul_b = 36'(spd_q);
				st_d = S_FF3;
			end
			S_FF3: begin
				mul_a = $signed({prod[31:0], 4'd0});
				mul_b = $signed({4'd0, ld_q});
				st_d = S_FF4;
			end
			S_FF4: begin
				mul_a = $signed({{8{spd_q[15]}}, spd_q, 12'd0});
				mul_b = $signed({4'd0, flux_q});
				st_d = S_FF5;
			end
			S_FF5: st_d = S_SQ0;
			S_SQ0: begin
				mul_a = 36'(vu_q[0]);
				mul_b = 36'(vu_q[0]);
				st_d = S_SQ1;
			end
			S_SQ1: begin
				mul_a = 36'(vu_q[1]);
				mul_b = 36'(vu_q[1]);
				st_d = S_SQ2;
			end
			S_SQ2: begin
				sq_start = 1'b1;
				mul_a = $signed({12'd0, vdc_q, 8'd0});
				mul_b = $signed({4'd0, INV_SQRT3_Q32});
				st_d = S_VMAX;
			end
			S_VMAX: st_d = S_SQW;
			S_SQW: begin
				if (sq_done) st_d = S_LIM0;
			end
			S_LIM0: begin
				mul_a = $signed({4'd0, av_c});
				mul_b = $signed({12'd0, vmax_q});
				st_d = S_LIM1;
			end
			S_LIM1: begin
				dv_start = 1'b1;
				st_d = S_LIM2;
			end
			S_LIM2: begin
				if (dv_done) st_d = ax_q ? S_DONE : S_LIM0;
			end
			S_DONE: begin
				if (out_free) st_d = S_IDLE;
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			res_valid_q <= 1'b0;
			kp_d_q <= '0;
			ki_d_q <= '0;
			kp_q_q <= '0;
			ki_q_q <= '0;
			sp_q <= SAMPLE_PERIOD_RST;
			ld_q <= '0;
			lq_q <= '0;
			flux_q <= '0;
			integ_q[0] <= '0;
			integ_q[1] <= '0;
			exc_q[0] <= '0;
			exc_q[1] <= '0;
			ax_q <= 1'b0;
			j_q <= '0;
		end else begin
			st_q <= st_d;
			if (cfg.valid) begin
				case (cfg.index)
					REG_KP_D: kp_d_q <= cfg.data;
					REG_KI_D: ki_d_q <= cfg.data;
					REG_KP_Q: kp_q_q <= cfg.data;
					REG_KI_Q: ki_q_q <= cfg.data;
					REG_SAMPLE_PERIOD: sp_q <= cfg.data;
					REG_INDUCTANCE_D: ld_q <= cfg.data;
					REG_INDUCTANCE_Q: lq_q <= cfg.data;
					REG_FLUX_LINKAGE: flux_q <= cfg.data;
					default: ;
				endcase
			end
			if (st_q == S_DONE && out_free) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					j_q <= '0;
					ax_q <= 1'b0;
				end
				S_SACC: j_q <= j_q + 3'd1;
				S_PI4: integ_q[ax_q] <= integ_c;
				S_PI5: ax_q <= !ax_q;
				S_SQW: ax_q <= 1'b0;
				S_LIM2: begin
					if (dv_done) ax_q <= 1'b1;
				end
				S_DONE: begin
					if (out_free) begin
						exc_q[0] <= sat32(72'(vl_q[0]) - 72'(vu_q[0]));
						exc_q[1] <= sat32(72'(vl_q[1]) - 72'(vu_q[1]));
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				ia_q <= sample.phase_current_a;
				ib_q <= sample.phase_current_b;
				ic_q <= sample.phase_current_c;
				ang_q <= sample.rotor_angle;
				refd_q <= sample.current_ref_d;
				refq_q <= sample.current_ref_q;
				spd_q <= sample.electrical_speed;
				vdc_q <= sample.bus_voltage;
				sd_q <= '0;
				sq_q <= '0;
				hit_q <= 1'b0;
			end
			S_LUT: begin
				t0_q <= SINE_TAB[idx_c];
				t1_q <= SINE_TAB[SINE_IDX_W'(idx_c + 1'b1)];
				frac_q <= ph_c << SINE_IDX_W;
			end
			S_SACC: begin
				if (j_q < 3'd3) begin
					sd_q <= sd_q + prod[33:0];
				end else begin
					sq_q <= sq_q + prod[33:0];
				end
			end
			S_PRKQ: id_q <= park_c;
			S_PRKE: iq_q <= park_c;
			S_PI0: begin
				err_q <= err_c;
				w_q <= w_c;
			end
			S_PI2: hi_q <= prod[63:32];
			S_PI3: lor_q <= 33'((prod + 72'sh8000_0000) >>> 32);
			S_PI5: p_q[ax_q] <= pout_c;
			S_FF2: ffd_q <= rnd_c[39:0];
			S_FF4: ffq_q <= rnd_c[39:0];
			S_FF5: begin
				vu_q[0] <= vd_c;
				vu_q[1] <= vq_c;
			end
			S_SQ1: sum_q <= prod[63:0];
			S_VMAX: vmax_q <= rnd_c[23:0];
			S_SQW: begin
				if (sq_done) mag_q <= (sq_root == '0) ? MAG_FLOOR : sq_root;
			end
			S_LIM2: begin
				if (dv_done) begin
					vl_q[ax_q] <= vl_c;
					if (vl_c != vsel_c) hit_q <= 1'b1;
				end
			end
			S_DONE: begin
				if (out_free) begin
					res_vd_q <= sat16((72'(vl_q[0]) + 72'sd128) >>> 8);
					res_vq_q <= sat16((72'(vl_q[1]) + 72'sd128) >>> 8);
					res_md_q <= id_q;
					res_mq_q <= iq_q;
					res_lim_q <= hit_q;
				end
			end
			default: ;
		endcase
	end
endmodule

// ===== design/foc_checker.sv =====
// ----------------------------------------------------------------------------
// foc_port_checks
// Port-level checks of the current loop, bound to the top level.
// ----------------------------------------------------------------------------
module foc_port_checks (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	input logic sample_ready,
	input logic result_valid,
	input logic result_ready,
	input logic [15:0] result_vd,
	input logic [15:0] result_vq
);
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("Result valid dropped before its transaction completed.");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result_vd) && $stable(result_vq))
		else $error("Result payload changed while stalled.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("Sample channel stayed ready after a transaction.");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(!sample_ready))
		else $error("Result appeared without a sample in progress.");
endmodule

bind foc_current_loop foc_port_checks u_foc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.sample_valid(sample.valid),
	.sample_ready(sample.ready),
	.result_valid(result.valid),
	.result_ready(result.ready),
	.result_vd(result.voltage_ref_d),
	.result_vq(result.voltage_ref_q)
);
